[src/fbtwd_pkg.sv]
// Package with the letter codes, result types and lane types of the five-bit text word decoder.
package fbtwd_pkg;

	localparam int LANES   = 3;
	localparam int LANE_RES = 4;
	localparam int MAX_RES = 8;
	localparam int CNT_RES_W = 4;

	localparam logic [4:0] LT_LAST_ALPHA = 5'd25;
	localparam logic [4:0] LT_SPACE      = 5'd26;
	localparam logic [4:0] LT_PERIOD     = 5'd27;
	localparam logic [4:0] LT_BREAK      = 5'd28;
	localparam logic [4:0] LT_TILDE      = 5'd29;
	localparam logic [4:0] LT_ESC        = 5'd30;
	localparam logic [4:0] LT_END        = 5'd31;

	localparam logic [4:0] ESC_BANG = 5'd1;
	localparam logic [4:0] ESC_THE  = 5'd2;
	localparam logic [4:0] ESC_YOU  = 5'd3;

	typedef struct packed {
		logic [7:0] ch;
		logic       brk;
		logic       tend;
	} res_t;

	typedef struct packed {
		logic [2:0]                cnt;
		res_t [LANE_RES-1:0]       ent;
		logic                      is_end;
		logic                      esc_out;
	} lane_t;

endpackage

[src/fbtwd_lane.sv]
// One decoding lane: turns a single letter and its escape state into up to four results.
module fbtwd_lane import fbtwd_pkg::*; (
	input  logic [4:0] letter,
	input  logic       esc_in,
	output lane_t      lane
);

	res_t r;
	logic has_r;

	always_comb begin
		r = '0;
		has_r = 1'b1;
		if (letter <= LT_LAST_ALPHA) begin
			r.ch = 8'h41 + {3'b000, letter};
		end else begin
			case (letter)
				LT_SPACE:  r.ch = " ";
				LT_PERIOD: r.ch = ".";
				LT_BREAK:  r.brk = 1'b1;
				LT_TILDE:  r.ch = "~";
				LT_ESC:    has_r = 1'b0;
				LT_END:    r.tend = 1'b1;
				default:   has_r = 1'b0;
			endcase
		end
	end

	always_comb begin
		lane = '0;
		lane.is_end = (letter == LT_END);
		lane.esc_out = (letter == LT_ESC);
		if (esc_in && letter == ESC_BANG) begin
			lane.ent[0].ch = "!";
			lane.cnt = 3'd1;
		end else if (esc_in && letter == ESC_THE) begin
			lane.ent[0].ch = "T";
			lane.ent[1].ch = "H";
			lane.ent[2].ch = "E";
			lane.ent[3].ch = " ";
			lane.cnt = 3'd4;
		end else if (esc_in && letter == ESC_YOU) begin
			lane.ent[0].ch = "Y";
			lane.ent[1].ch = "O";
			lane.ent[2].ch = "U";
			lane.ent[3].ch = " ";
			lane.cnt = 3'd4;
		end else if (esc_in) begin
			// The unresolved escape gives a null result ahead of the letter.
			lane.ent[1] = r;
			lane.cnt = 3'd1 + {2'b00, has_r};
		end else begin
			lane.ent[0] = r;
			lane.cnt = {2'b00, has_r};
		end
	end

endmodule

[src/fbtwd_merge.sv]
// Merging stage: packs the results of the three lanes into one ordered list for the word.
module fbtwd_merge import fbtwd_pkg::*; (
	input  lane_t [LANES-1:0]   lanes,
	output res_t [MAX_RES-1:0]  list,
	output logic [CNT_RES_W-1:0] cnt,
	output logic                is_end,
	output logic                esc_out
);

	logic [LANES-1:0] active;
	logic [CNT_RES_W-1:0] ceff [LANES];
	logic [CNT_RES_W-1:0] off [LANES];
	logic [CNT_RES_W-1:0] pos;

	always_comb begin
		active[0] = 1'b1;
		active[1] = !lanes[0].is_end;
		active[2] = active[1] && !lanes[1].is_end;
		for (int k = 0; k < LANES; k++) begin
			ceff[k] = active[k] ? {1'b0, lanes[k].cnt} : '0;
		end
		off[0] = '0;
		off[1] = ceff[0];
		off[2] = ceff[0] + ceff[1];
		cnt = off[2] + ceff[2];
		is_end = |(active & {lanes[2].is_end, lanes[1].is_end, lanes[0].is_end});
		esc_out = active[2] && lanes[2].esc_out;
	end

	always_comb begin
		list = '0;
		pos = '0;
		for (int k = 0; k < LANES; k++) begin
			for (int e = 0; e < LANE_RES; e++) begin
				pos = off[k] + CNT_RES_W'(e);
				if (CNT_RES_W'(e) < ceff[k] && pos < CNT_RES_W'(MAX_RES)) begin
					list[pos[2:0]] = lanes[k].ent[e];
				end
			end
		end
	end

endmodule

[src/five_bit_text_word_decoder_core.sv]
// Top level of the five-bit text word decoder: input stage, lanes, result buffer and output.
//
// Each accepted item on the word channel is a 16-bit code word with three 5-bit
// letters, the first in bits 14..10. Every item gives one to eight result items
// on the char channel, in order, with last set on the final one of the word.
// Both channels move an item at a rising edge where valid is high and stall low.
// A word goes into the input register, is decoded by three letter lanes and
// merged into a result buffer, from which its results pass to the output
// register. Results leave at one per cycle while the receiver does not stall,
// three of them for a plain word, while the next word is already accepted and
// decoded behind it. The result buffer drains into the output register one
// entry a cycle when not stalled; that serialization sets the rate.
// When the receiver stalls, the output register holds its item and the stall
// backs up through the buffer to the word channel. Reset empties all stages,
// clears a pending escape and sets the text number to zero.
module five_bit_text_word_decoder_core import fbtwd_pkg::*; #(
	parameter int MAX_TEXTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        word_valid,
	output logic        word_stall,
	input  logic [15:0] code_word,
	output logic        char_valid,
	input  logic        char_stall,
	output logic [7:0]  out_char,
	output logic        line_break,
	output logic        text_end,
	output logic [9:0]  text_number,
	output logic        last
);

	localparam int CNT_W = (MAX_TEXTS > 1) ? $clog2(MAX_TEXTS) : 1;
	localparam int TN_W = (CNT_W > 10) ? CNT_W : 10;

	logic [15:0] word_s1;
	logic        valid_s1;
	logic        s1_adv;

	logic             escape_q;
	logic [CNT_W-1:0] counter_q;
	logic [TN_W-1:0]  tn_wide;

	logic [4:0]           letters [LANES];
	logic [LANES-1:0]     esc_in;
	lane_t [LANES-1:0]    lanes;
	res_t [MAX_RES-1:0]   merged;
	logic [CNT_RES_W-1:0] merged_cnt;
	logic                 merged_end;
	logic                 merged_esc;

	res_t [MAX_RES-1:0]   list_s2;
	logic [CNT_RES_W-1:0] cnt_s2;
	logic [2:0]           idx_s2;
	logic [9:0]           tn_s2;
	logic                 valid_s2;
	logic                 s2_final;
	logic                 s2_free;
	logic                 out_free;

	logic       char_valid_q;
	logic [7:0] out_char_q;
	logic       line_break_q;
	logic       text_end_q;
	logic [9:0] text_number_q;
	logic       last_q;

	assign letters[0] = word_s1[14:10];
	assign letters[1] = word_s1[9:5];
	assign letters[2] = word_s1[4:0];
	assign esc_in[0] = escape_q;
	assign esc_in[1] = (letters[0] == LT_ESC);
	assign esc_in[2] = (letters[1] == LT_ESC);

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		fbtwd_lane u_lane (
			.letter (letters[k]),
			.esc_in (esc_in[k]),
			.lane   (lanes[k])
		);
	end

	fbtwd_merge u_merge (
		.lanes   (lanes),
		.list    (merged),
		.cnt     (merged_cnt),
		.is_end  (merged_end),
		.esc_out (merged_esc)
	);

	assign tn_wide = TN_W'(counter_q);

	assign out_free = !char_valid_q || !char_stall;
	assign s2_final = ({1'b0, idx_s2} + 4'd1) == cnt_s2;
	assign s2_free = !valid_s2 || (out_free && s2_final);
	assign s1_adv = valid_s1 && s2_free;
	assign word_stall = valid_s1 && !s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (word_valid && !word_stall) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (word_valid && !word_stall) begin
			word_s1 <= code_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= 1'b0;
			counter_q <= '0;
		end else if (s1_adv) begin
			escape_q <= merged_esc;
			if (merged_end) begin
				if (counter_q == CNT_W'(MAX_TEXTS - 1)) begin
					counter_q <= '0;
				end else begin
					counter_q <= counter_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2 <= '0;
		end else if (s1_adv) begin
			valid_s2 <= (merged_cnt != '0);
			idx_s2 <= '0;
		end else if (valid_s2 && out_free) begin
			if (s2_final) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_s2 <= idx_s2 + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			list_s2 <= merged;
			cnt_s2 <= merged_cnt;
			tn_s2 <= tn_wide[9:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_q <= 1'b0;
		end else if (out_free) begin
			char_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			out_char_q <= list_s2[idx_s2].ch;
			line_break_q <= list_s2[idx_s2].brk;
			text_end_q <= list_s2[idx_s2].tend;
			text_number_q <= tn_s2;
			last_q <= s2_final;
		end
	end

	assign char_valid = char_valid_q;
	assign out_char = out_char_q;
	assign line_break = line_break_q;
	assign text_end = text_end_q;
	assign text_number = text_number_q;
	assign last = last_q;

`ifndef SYNTHESIS
	a_buf_index: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ({1'b0, idx_s2} < cnt_s2))
		else $error("result buffer index beyond its count");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && text_end |-> last)
		else $error("text end result is not the last of its word");

	a_end_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && merged_end && MAX_TEXTS > 1) |=> (counter_q != $past(counter_q)))
		else $error("text number did not advance after a text end");

	a_mark_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> !(line_break && text_end))
		else $error("line break and text end on one result");
`endif

endmodule

[sim/five_bit_text_word_decoder_core_test.sv]
// Self-checking testbench for the five-bit text word decoder core.
`timescale 1ns / 1ps

module five_bit_text_word_decoder_core_test;
	import fbtwd_pkg::*;

	localparam int RANDOM_WORDS = 385;
	localparam int TAIL_WORDS   = 60;
	localparam int TEXT_WRAP    = 1024;
	localparam int STUCK_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 12;

	typedef struct packed {
		logic [7:0] ch;
		logic       brk;
		logic       tend;
		logic [9:0] num;
		logic       last;
	} char_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        word_valid = 1'b0;
	logic        word_stall;
	logic [15:0] code_word = 16'd0;
	logic        char_valid;
	logic        char_stall = 1'b0;
	logic [7:0]  out_char;
	logic        line_break;
	logic        text_end;
	logic [9:0]  text_number;
	logic        last;

	logic [15:0] word_queue [$];
	char_res_t   expected_chars [$];
	logic        esc_open = 1'b0;
	logic [9:0]  text_count = 10'd0;
	logic        word_taken = 1'b0;
	int          word_gap = 0;
	int          stall_left = 0;
	int          stuck_cycles = 0;
	int          err_count = 0;
	int          words_done = 0;
	int          chars_done = 0;
	int          texts_done = 0;
	int          escapes_done = 0;

	five_bit_text_word_decoder_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.word_valid(word_valid),
		.word_stall(word_stall),
		.code_word(code_word),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.out_char(out_char),
		.line_break(line_break),
		.text_end(text_end),
		.text_number(text_number),
		.last(last)
	);

	always #6 clk = ~clk;

	function automatic void put_char(input logic [7:0] ch, input logic brk, input logic tend);
		char_res_t r;
		r.ch = ch;
		r.brk = brk;
		r.tend = tend;
		r.num = text_count;
		r.last = 1'b0;
		expected_chars.push_back(r);
	endfunction

	function automatic void put_phrase(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		put_char(a, 1'b0, 1'b0);
		put_char(b, 1'b0, 1'b0);
		put_char(c, 1'b0, 1'b0);
		put_char(" ", 1'b0, 1'b0);
	endfunction

	// Returns 1 when the letter closes the current text.
	function automatic bit decode_letter(input logic [4:0] lt);
		if (esc_open) begin
			esc_open = 1'b0;
			escapes_done++;
			case (lt)
				ESC_BANG: begin
					put_char("!", 1'b0, 1'b0);
					return 1'b0;
				end
				ESC_THE: begin
					put_phrase("T", "H", "E");
					return 1'b0;
				end
				ESC_YOU: begin
					put_phrase("Y", "O", "U");
					return 1'b0;
				end
				default: put_char(8'd0, 1'b0, 1'b0);
			endcase
		end
		if (lt <= LT_LAST_ALPHA) begin
			put_char("A" + {3'd0, lt}, 1'b0, 1'b0);
			return 1'b0;
		end
		case (lt)
			LT_SPACE: put_char(" ", 1'b0, 1'b0);
			LT_PERIOD: put_char(".", 1'b0, 1'b0);
			LT_BREAK: put_char(8'd0, 1'b1, 1'b0);
			LT_TILDE: put_char("~", 1'b0, 1'b0);
			LT_ESC: esc_open = 1'b1;
			default: begin
				put_char(8'd0, 1'b0, 1'b1);
				texts_done++;
				text_count = 10'((int'(text_count) + 1) % TEXT_WRAP);
				return 1'b1;
			end
		endcase
		return 1'b0;
	endfunction

	function automatic void decode_word(input logic [15:0] w);
		int first_idx;
		int k;
		first_idx = expected_chars.size();
		for (k = 0; k < 3; k++) begin
			if (decode_letter(w[14 - 5 * k -: 5]))
				break;
		end
		if (expected_chars.size() > first_idx)
			expected_chars[expected_chars.size() - 1].last = 1'b1;
	endfunction

	function automatic logic [15:0] pack_word(input logic top, input logic [4:0] a,
			input logic [4:0] b, input logic [4:0] c);
		return {top, a, b, c};
	endfunction

	function automatic logic [4:0] pick_letter();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 5'($urandom_range(0, LT_LAST_ALPHA));
			4: return 5'($urandom_range(LT_SPACE, LT_TILDE));
			5, 6: return LT_ESC;
			7: return 5'($urandom_range(ESC_BANG, ESC_YOU));
			8: return LT_END;
			default: return 5'($urandom_range(0, 31));
		endcase
	endfunction

	// Word driver: a new item is presented once the previous one has been taken.
	always @(negedge clk) begin
		if (arst_n && (!word_valid || word_taken)) begin
			if (word_gap > 0 && word_queue.size() >= TAIL_WORDS) begin
				word_gap--;
				word_valid <= 1'b0;
			end else if (word_queue.size() > 0) begin
				word_gap = 0;
				word_valid <= 1'b1;
				code_word <= word_queue.pop_front();
				if (word_queue.size() >= TAIL_WORDS && $urandom_range(0, 7) == 0)
					word_gap = $urandom_range(1, 16);
			end else begin
				word_valid <= 1'b0;
			end
		end
	end

	// Receiver stall in bursts, none in the tail of the run.
	always @(negedge clk) begin
		if (word_queue.size() < TAIL_WORDS) begin
			stall_left = 0;
			char_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			char_stall <= 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 16) - 1;
			char_stall <= 1'b1;
		end else begin
			char_stall <= 1'b0;
		end
	end

	// Monitor: predicts on accepted words and checks accepted characters.
	always @(posedge clk) begin
		char_res_t got;
		char_res_t want;
		word_taken <= word_valid && !word_stall;
		if (arst_n) begin
			if (word_valid && !word_stall) begin
				decode_word(code_word);
				words_done++;
			end
			if (char_valid && !char_stall) begin
				got = {out_char, line_break, text_end, text_number, last};
				chars_done++;
				if (expected_chars.size() == 0) begin
					err_count++;
					$display("%0t: unexpected item: ch=%h brk=%b end=%b num=%0d last=%b",
						$time, got.ch, got.brk, got.tend, got.num, got.last);
				end else begin
					want = expected_chars.pop_front();
					if (got !== want) begin
						err_count++;
						$display({"%0t: mismatch: expected ch=%h brk=%b end=%b num=%0d last=%b,",
							" got ch=%h brk=%b end=%b num=%0d last=%b"}, $time,
							want.ch, want.brk, want.tend, want.num, want.last,
							got.ch, got.brk, got.tend, got.num, got.last);
					end
				end
			end
			if ((word_valid && !word_stall) || (char_valid && !char_stall))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int i;
		// Letter extremes, every symbol, and the end letter in each position.
		word_queue.push_back(pack_word(1'b0, 5'd0, 5'd0, 5'd0));
		word_queue.push_back(pack_word(1'b1, LT_LAST_ALPHA, LT_SPACE, LT_PERIOD));
		word_queue.push_back(pack_word(1'b0, LT_BREAK, LT_TILDE, LT_END));
		word_queue.push_back(pack_word(1'b1, 5'd7, LT_END, 5'd4));
		word_queue.push_back(pack_word(1'b0, LT_END, 5'd1, 5'd2));
		word_queue.push_back(16'hFFFF);
		word_queue.push_back(16'h7FFF);
		word_queue.push_back(16'h8000);
		// Escapes resolved within a word and across word boundaries.
		word_queue.push_back(pack_word(1'b0, LT_ESC, ESC_BANG, LT_ESC));
		word_queue.push_back(pack_word(1'b1, ESC_THE, LT_ESC, ESC_YOU));
		word_queue.push_back(pack_word(1'b0, LT_ESC, ESC_THE, 5'd10));
		word_queue.push_back(pack_word(1'b0, LT_ESC, LT_ESC, 5'd5));
		word_queue.push_back(pack_word(1'b1, LT_ESC, LT_END, 5'd0));
		word_queue.push_back(pack_word(1'b0, LT_ESC, 5'd0, LT_ESC));
		word_queue.push_back(pack_word(1'b0, LT_END, 5'd3, 5'd3));
		word_queue.push_back(pack_word(1'b0, 5'd1, 5'd2, LT_ESC));
		word_queue.push_back(pack_word(1'b1, ESC_THE, LT_ESC, ESC_YOU));
		word_queue.push_back(pack_word(1'b0, LT_ESC, LT_BREAK, LT_ESC));
		word_queue.push_back(pack_word(1'b0, LT_TILDE, LT_ESC, 5'd0));
		word_queue.push_back(pack_word(1'b1, LT_ESC, LT_ESC, LT_ESC));
		word_queue.push_back(pack_word(1'b0, ESC_YOU, LT_END, 5'd0));
		word_queue.push_back(16'h5555);
		word_queue.push_back(16'hAAAA);
		for (i = 0; i < RANDOM_WORDS; i++) begin
			if ($urandom_range(0, 9) < 3)
				word_queue.push_back(16'($urandom_range(0, 65535)));
			else
				word_queue.push_back(pack_word(1'($urandom_range(0, 1)), pick_letter(),
					pick_letter(), pick_letter()));
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (word_queue.size() != 0 || word_valid)
			@(posedge clk);
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Decoded %0d code words into %0d characters, %0d text ends, %0d escapes.",
			words_done, chars_done, texts_done, escapes_done);
		if (err_count == 0 && expected_chars.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d errors, %0d characters still expected", err_count,
				expected_chars.size());
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
